// ===== design/ttt_pkg.sv =====
// Shared types and constants for the timeout timer table.
package ttt_pkg;

  typedef enum logic [3:0] {
    S_IDLE,
    S_ADD,
    S_ADD_DIV,
    S_ADD_WR,
    S_C_RD,
    S_C_CHK,
    S_C_MOV,
    S_E1_RD,
    S_E1_CHK,
    S_E2_RD,
    S_E2_CHK,
    S_E2_MOV,
    S_Q_RD,
    S_Q_MUL,
    S_Q_SUM
  } state_t;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_CANCEL = 2'd1;
  localparam logic [1:0] OP_EXPIRE = 2'd2;
  localparam logic [1:0] OP_QUERY  = 2'd3;

  localparam logic [2:0] ST_ADDED     = 3'd0;
  localparam logic [2:0] ST_FULL      = 3'd1;
  localparam logic [2:0] ST_CANCELLED = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_EXPIRED   = 3'd4;
  localparam logic [2:0] ST_NONE      = 3'd5;

  typedef struct packed {
    logic [30:0] id;
    logic [32:0] sec;
    logic [19:0] usec;
    logic [31:0] tag;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

  localparam logic [9:0]  MS_PER_SEC   = 10'd1000;
  localparam logic [20:0] USEC_PER_SEC = 21'd1000000;
  // ceil(2^31 / 1000); exact for dividends below 2^21.
  localparam logic [21:0] RECIP_1000   = 22'd2147484;
  localparam int          RECIP_SHIFT  = 31;
  // ceil(2^38 / 1000); exact for every 31-bit dividend.
  localparam logic [28:0] DIV_RECIP    = 29'd274877907;
  localparam int          DIV_SHIFT    = 38;
  localparam logic [30:0] MS_CLAMP     = 31'h7FFFFFFF;

endpackage

// ===== design/ttt_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module ttt_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== design/ttt_div.sv =====
// Division of a 31-bit value by 1000 through a reciprocal multiply.
module ttt_div (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [30:0] dividend,
  output logic        done,
  output logic [30:0] quotient,
  output logic [9:0]  remainder
);
  import ttt_pkg::*;

  logic        mul_pend;
  logic        sub_pend;
  logic [30:0] dvd;
  logic [59:0] prod;
  logic [30:0] back;

  assign prod = dvd * DIV_RECIP;
  assign back = 31'(quotient * MS_PER_SEC);

  always_ff @(posedge clk) begin
    if (rst) begin
      mul_pend <= 1'b0;
      sub_pend <= 1'b0;
      done     <= 1'b0;
    end else begin
      mul_pend <= start;
      sub_pend <= mul_pend;
      done     <= sub_pend;
    end
  end

  // Quotient first, then the remainder from the quotient scaled back.
  always_ff @(posedge clk) begin
    if (start) begin
      dvd <= dividend;
    end
    if (mul_pend) begin
      quotient <= 31'(prod[DIV_SHIFT +: 22]);
    end
    if (sub_pend) begin
      remainder <= 10'(dvd - back);
    end
  end

endmodule

// ===== design/timeout_timer_table_core.sv =====
// Top level of the timeout timer table: sequencer, entry RAM and time arithmetic.
// Add computes the expiry through the reciprocal divider; cancel scans entries for the id;
// expire counts due timers in a first pass and removes them in a second; query scans every
// live entry for the least remaining time. One item at a time; busy is high while working.
// Results are strobed for one cycle, cannot be held off. Reset empties the table and sets
// the next id to 1; the RAM itself is not cleared.
module timeout_timer_table_core #(
  parameter int TABLE_DEPTH = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [31:0] now_sec,
  input  logic [19:0] now_usec,
  input  logic [30:0] delay_ms,
  input  logic [30:0] cancel_id,
  input  logic [31:0] user_tag,
  output logic        result_valid,
  output logic [2:0]  status,
  output logic [30:0] result_id,
  output logic [31:0] result_tag,
  output logic [30:0] remaining_ms,
  output logic [$clog2(TABLE_DEPTH+1)-1:0] live_count,
  output logic        last
);
  import ttt_pkg::*;

  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam logic [CW-1:0] DEPTH_C = CW'(TABLE_DEPTH);

  state_t state, state_next;

  logic [31:0] now_s_r;
  logic [19:0] now_u_r;
  logic [30:0] tmo_r;
  logic [30:0] cid_r;
  logic [31:0] tag_r;

  logic [CW-1:0] count, idx, due_cnt, emitted, final_cnt;
  logic [30:0]   next_id, id_inc;
  logic [30:0]   best;

  logic signed [44:0] prod_s;
  logic [10:0]        du_q;
  logic               du_neg;

  entry_t rd_data, new_entry;
  logic   ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  entry_t ram_wdata;

  logic        div_start, div_done;
  logic [30:0] div_q;
  logic [9:0]  div_r;

  logic          emit, emit_last;
  logic [2:0]    emit_status;
  logic [30:0]   emit_id, emit_rem;
  logic [31:0]   emit_tag;
  logic [CW-1:0] emit_live;

  logic idx_end, idx_not_last, rd_due;

  ttt_ram #(.WIDTH(ENTRY_W), .DEPTH(TABLE_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (rd_data)
  );

  ttt_div u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (tmo_r),
    .done      (div_done),
    .quotient  (div_q),
    .remainder (div_r)
  );

  function automatic logic is_due(entry_t e, logic [31:0] s, logic [19:0] u);
    return ({1'b0, s} > e.sec) || (({1'b0, s} == e.sec) && (u >= e.usec));
  endfunction

  assign idx_end      = idx >= count;
  assign idx_not_last = ({1'b0, idx} + (CW + 1)'(1)) < {1'b0, count};
  assign rd_due       = is_due(rd_data, now_s_r, now_u_r);
  assign id_inc       = (next_id == MS_CLAMP) ? 31'd1 : next_id + 31'd1;
  assign busy         = state != S_IDLE;

  // Expiry of a new timer: carry one second when the microseconds overflow.
  logic [32:0] add_sec;
  logic [20:0] add_usec;
  always_comb begin
    add_sec  = {1'b0, now_s_r} + {2'b0, div_q};
    add_usec = {1'b0, now_u_r} + 21'(div_r * MS_PER_SEC);
    if (add_usec >= USEC_PER_SEC) begin
      add_sec  = add_sec + 33'd1;
      add_usec = add_usec - USEC_PER_SEC;
    end
    new_entry.id   = next_id;
    new_entry.sec  = add_sec;
    new_entry.usec = add_usec[19:0];
    new_entry.tag  = tag_r;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    ram_we      = 1'b0;
    ram_waddr   = idx[AW-1:0];
    ram_wdata   = rd_data;
    ram_raddr   = idx[AW-1:0];
    div_start   = 1'b0;
    emit        = 1'b0;
    emit_status = ST_NONE;
    emit_id     = '0;
    emit_tag    = '0;
    emit_rem    = '0;
    emit_live   = count;
    emit_last   = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          unique case (opcode)
            OP_ADD:    state_next = S_ADD;
            OP_CANCEL: state_next = S_C_RD;
            OP_EXPIRE: state_next = S_E1_RD;
            OP_QUERY:  state_next = S_Q_RD;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_ADD: begin
        if (count >= DEPTH_C) begin
          emit        = 1'b1;
          emit_status = ST_FULL;
          state_next  = S_IDLE;
        end else begin
          div_start  = 1'b1;
          state_next = S_ADD_DIV;
        end
      end
      S_ADD_DIV: begin
        if (div_done) begin
          state_next = S_ADD_WR;
        end
      end
      S_ADD_WR: begin
        ram_we      = 1'b1;
        ram_waddr   = count[AW-1:0];
        ram_wdata   = new_entry;
        emit        = 1'b1;
        emit_status = ST_ADDED;
        emit_id     = next_id;
        emit_live   = count + CW'(1);
        state_next  = S_IDLE;
      end
      S_C_RD: begin
        if (idx_end) begin
          emit        = 1'b1;
          emit_status = ST_NOT_FOUND;
          state_next  = S_IDLE;
        end else begin
          state_next = S_C_CHK;
        end
      end
      S_C_CHK: begin
        if (rd_data.id == cid_r) begin
          ram_raddr = AW'(count - CW'(1));
          if (idx_not_last) begin
            state_next = S_C_MOV;
          end else begin
            emit        = 1'b1;
            emit_status = ST_CANCELLED;
            emit_live   = count - CW'(1);
            state_next  = S_IDLE;
          end
        end else begin
          state_next = S_C_RD;
        end
      end
      S_C_MOV: begin
        ram_we      = 1'b1;
        emit        = 1'b1;
        emit_status = ST_CANCELLED;
        emit_live   = count - CW'(1);
        state_next  = S_IDLE;
      end
      S_E1_RD: begin
        if (idx_end) begin
          if (due_cnt == '0) begin
            emit        = 1'b1;
            emit_status = ST_NONE;
            state_next  = S_IDLE;
          end else begin
            state_next = S_E2_RD;
          end
        end else begin
          state_next = S_E1_CHK;
        end
      end
      S_E1_CHK: state_next = S_E1_RD;
      S_E2_RD: begin
        state_next = idx_end ? S_IDLE : S_E2_CHK;
      end
      S_E2_CHK: begin
        if (rd_due) begin
          emit        = 1'b1;
          emit_status = ST_EXPIRED;
          emit_id     = rd_data.id;
          emit_tag    = rd_data.tag;
          emit_live   = final_cnt;
          emit_last   = (emitted + CW'(1)) == due_cnt;
          ram_raddr   = AW'(count - CW'(1));
          if (idx_not_last) begin
            state_next = S_E2_MOV;
          end else begin
            state_next = emit_last ? S_IDLE : S_E2_RD;
          end
        end else begin
          state_next = S_E2_RD;
        end
      end
      S_E2_MOV: begin
        ram_we     = 1'b1;
        state_next = (emitted == due_cnt) ? S_IDLE : S_E2_RD;
      end
      S_Q_RD: begin
        if (idx_end) begin
          emit        = 1'b1;
          emit_status = (count == '0) ? ST_NONE : ST_ADDED;
          emit_rem    = (count == '0) ? 31'd0 : best;
          state_next  = S_IDLE;
        end else begin
          state_next = S_Q_MUL;
        end
      end
      S_Q_MUL: state_next = S_Q_SUM;
      S_Q_SUM: state_next = S_Q_RD;
      default: state_next = S_IDLE;
    endcase
  end

  // Remaining time of the entry just read: seconds scaled here, microseconds
  // divided by 1000 through a reciprocal, truncating toward zero.
  logic signed [33:0] ds;
  logic signed [20:0] du;
  logic [20:0]        du_abs;
  logic [42:0]        du_prod;
  logic signed [45:0] ms_raw;
  logic [30:0]        ms_clamped;

  always_comb begin
    ds      = signed'({1'b0, rd_data.sec}) - signed'({2'b0, now_s_r});
    du      = signed'({1'b0, rd_data.usec}) - signed'({1'b0, now_u_r});
    du_abs  = du[20] ? 21'(-du) : 21'(du);
    du_prod = du_abs * RECIP_1000;
    ms_raw  = 46'(prod_s) + (du_neg ? -46'(signed'({1'b0, du_q})) : 46'(signed'({1'b0, du_q})));
    if (ms_raw < 0) begin
      ms_clamped = '0;
    end else if (ms_raw > 46'(signed'({1'b0, MS_CLAMP}))) begin
      ms_clamped = MS_CLAMP;
    end else begin
      ms_clamped = ms_raw[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      next_id <= 31'd1;
    end else begin
      case (state)
        S_ADD_WR: begin
          count   <= count + CW'(1);
          next_id <= id_inc;
        end
        S_C_CHK: begin
          if (rd_data.id == cid_r && !idx_not_last) begin
            count <= count - CW'(1);
          end
        end
        S_C_MOV:  count <= count - CW'(1);
        S_E2_CHK: begin
          if (rd_due && !idx_not_last) begin
            count <= count - CW'(1);
          end
        end
        S_E2_MOV: count <= count - CW'(1);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (start) begin
          now_s_r <= now_sec;
          now_u_r <= now_usec;
          tmo_r   <= delay_ms;
          cid_r   <= cancel_id;
          tag_r   <= user_tag;
          idx     <= '0;
          due_cnt <= '0;
          emitted <= '0;
        end
      end
      S_C_CHK: begin
        if (rd_data.id != cid_r) begin
          idx <= idx + CW'(1);
        end
      end
      S_E1_RD: begin
        if (idx_end) begin
          idx       <= '0;
          final_cnt <= count - due_cnt;
        end
      end
      S_E1_CHK: begin
        if (rd_due) begin
          due_cnt <= due_cnt + CW'(1);
        end
        idx <= idx + CW'(1);
      end
      S_E2_CHK: begin
        if (rd_due) begin
          emitted <= emitted + CW'(1);
        end else begin
          idx <= idx + CW'(1);
        end
      end
      S_Q_MUL: begin
        prod_s <= 45'(ds) * 45'sd1000;
        du_q   <= du_prod[RECIP_SHIFT +: 11];
        du_neg <= du[20];
      end
      S_Q_SUM: begin
        if (idx == '0 || ms_clamped < best) begin
          best <= ms_clamped;
        end
        idx <= idx + CW'(1);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
    end
    status       <= emit_status;
    result_id    <= emit_id;
    result_tag   <= emit_tag;
    remaining_ms <= emit_rem;
    live_count   <= emit_live;
    last         <= emit_last;
  end

endmodule

// ===== design/ttt_checker.sv =====
// Port-level checks for the timeout timer table, bound to the top level.
module ttt_checker #(
  parameter int TABLE_DEPTH = 64
) (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        result_valid,
  input logic [2:0]  status,
  input logic [$clog2(TABLE_DEPTH+1)-1:0] live_count,
  input logic        last
);
  import ttt_pkg::*;

  // More words of the same item are still to come, so the block stays occupied.
  a_more_while_busy: assert property (@(posedge clk) disable iff (rst)
    result_valid && !last |-> busy)
    else $error("non-final result while not busy");

  a_no_result_after_accept: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> !result_valid)
    else $error("result in the cycle after accepting a word");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    result_valid && status == ST_FULL |-> live_count == ($clog2(TABLE_DEPTH+1))'(TABLE_DEPTH))
    else $error("table full reported with free entries");

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> live_count <= ($clog2(TABLE_DEPTH+1))'(TABLE_DEPTH))
    else $error("live count above table depth");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !busy && !result_valid)
    else $error("block not idle after reset");

endmodule

bind timeout_timer_table_core ttt_checker #(.TABLE_DEPTH(TABLE_DEPTH)) u_ttt_checker (
  .clk          (clk),
  .rst          (rst),
  .start        (start),
  .busy         (busy),
  .result_valid (result_valid),
  .status       (status),
  .live_count   (live_count),
  .last         (last)
);
